// ===== hdl/assert_macros.svh =====
// assertion helpers used by tagged_interval_set_merge
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge out of reset
`define TISM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define TISM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TISM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/tism_pkg.sv =====
package tism_pkg;

  localparam int unsigned TimeW   = 48;
  localparam int unsigned SchemaW = 16;
  localparam int unsigned HashW   = 32;
  localparam int unsigned OriginW = 8;
  localparam int unsigned TolW    = 32;
  // end plus tolerance with headroom so the sum never wraps
  localparam int unsigned ReachW  = TimeW + 2;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SPAN = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_IDX  = 2'd3;

  typedef struct packed {
    logic [TimeW-1:0]   span_start;
    logic [TimeW-1:0]   span_end;
    logic [SchemaW-1:0] schema;
    logic [HashW-1:0]   hash;
    logic [OriginW-1:0] origin;
  } entry_t;

  typedef struct packed {
    logic             hit;
    logic [TimeW-1:0] new_end;
  } fold_t;

endpackage

// ===== hdl/tism_fold.sv =====
module tism_fold (
  input  tism_pkg::entry_t           run_i,
  input  tism_pkg::entry_t           cand_i,
  input  logic [tism_pkg::TolW-1:0]  tol_i,
  output tism_pkg::fold_t            fold_o
);
  import tism_pkg::*;

  logic signed [ReachW-1:0] reach;
  logic signed [ReachW-1:0] cand_start;
  logic                     tags_eq;
  logic                     cand_longer;

  assign reach = $signed({{(ReachW-TimeW){run_i.span_end[TimeW-1]}}, run_i.span_end})
               + $signed({{(ReachW-TolW){1'b0}}, tol_i});
  assign cand_start = $signed({{(ReachW-TimeW){cand_i.span_start[TimeW-1]}},
                               cand_i.span_start});
  assign tags_eq = (run_i.schema == cand_i.schema) && (run_i.hash == cand_i.hash)
                && (run_i.origin == cand_i.origin);
  assign cand_longer = $signed(cand_i.span_end) > $signed(run_i.span_end);

  assign fold_o.hit     = tags_eq && (cand_start <= reach);
  assign fold_o.new_end = cand_longer ? cand_i.span_end : run_i.span_end;

endmodule

// ===== hdl/tagged_interval_set_merge.sv =====
// channel      | direction | signals                                    | transaction at
// -------------+-----------+--------------------------------------------+------------------------
// command      | in        | start, busy, operation_i .. read_index_i   | start high, busy low
// result       | out       | done_o, status_o .. out_origin_o           | every cycle done_o high
// tolerance    | in        | join_tolerance_we_i, join_tolerance_wdata_i| join_tolerance_we_i high
//
// clear, rejected inserts and out-of-range reads give their result on the cycle after the command;
// an in-range read first passes through S_RD_WAIT. an accepted insert shifts the entries it
// moves and then rescans all entries to merge, with one state to read and one to check each,
// as the entry memory has a single read port.
// reset is asynchronous and active low; it empties the table and zeroes the tolerance.
// the result strobe lasts one cycle and cannot be stalled; a new command may start in it.
`include "assert_macros.svh"

module tagged_interval_set_merge #(
  parameter int unsigned MAX_ENTRIES = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic                join_tolerance_we_i,
  input  logic [31:0]         join_tolerance_wdata_i,
  input  logic [1:0]          operation_i,
  input  logic                is_complete_i,
  input  logic signed [47:0]  span_start_i,
  input  logic signed [47:0]  span_end_i,
  input  logic [15:0]         schema_tag_i,
  input  logic [31:0]         hash_tag_i,
  input  logic [7:0]          origin_tag_i,
  input  logic [5:0]          read_index_i,
  output logic                done_o,
  output logic [1:0]          status_o,
  output logic [6:0]          entry_total_o,
  output logic signed [47:0]  out_start_o,
  output logic signed [47:0]  out_end_o,
  output logic [15:0]         out_schema_o,
  output logic [31:0]         out_hash_o,
  output logic [7:0]          out_origin_o
);
  import tism_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

  typedef logic [AW-1:0] idx_t;
  typedef logic [CW-1:0] cnt_t;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_RD_WAIT = 10'b0000000010,
    S_SH_RD   = 10'b0000000100,
    S_SH_CHK  = 10'b0000001000,
    S_INS_WR  = 10'b0000010000,
    S_MG_LD   = 10'b0000100000,
    S_MG_LDW  = 10'b0001000000,
    S_MG_RD   = 10'b0010000000,
    S_MG_EVAL = 10'b0100000000,
    S_MG_FIN  = 10'b1000000000
  } state_e;

  state_e         state_q, state_d;
  cnt_t           count_q, count_d;
  cnt_t           r_q, r_d;
  idx_t           pos_q, pos_d;
  idx_t           run_idx_q, run_idx_d;
  entry_t         run_q, run_d;
  entry_t         new_q, new_d;
  entry_t         res_q, res_d;
  logic [1:0]     status_q, status_d;
  logic           done_q, done_d;
  logic [TolW-1:0] tol_q;

  entry_t         mem_q [MAX_ENTRIES];
  entry_t         rdata_q;
  logic           mem_we, mem_re;
  idx_t           mem_waddr, mem_raddr;
  entry_t         mem_wdata;

  entry_t         in_entry;
  fold_t          fold;

  assign in_entry.span_start = span_start_i;
  assign in_entry.span_end   = span_end_i;
  assign in_entry.schema     = schema_tag_i;
  assign in_entry.hash       = hash_tag_i;
  assign in_entry.origin     = origin_tag_i;

  tism_fold u_fold (
    .run_i  (run_q),
    .cand_i (rdata_q),
    .tol_i  (tol_q),
    .fold_o (fold)
  );

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    r_d       = r_q;
    pos_d     = pos_q;
    run_idx_d = run_idx_q;
    run_d     = run_q;
    new_d     = new_q;
    res_d     = res_q;
    status_d  = status_q;
    done_d    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = pos_q;
    mem_wdata = new_q;
    mem_re    = 1'b0;
    mem_raddr = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          case (operation_i)
            OP_INSERT: begin
              if (!is_complete_i || (span_end_i <= span_start_i)) begin
                done_d   = 1'b1;
                status_d = ST_SPAN;
                res_d    = '0;
              end else if (count_q >= cnt_t'(MAX_ENTRIES)) begin
                done_d   = 1'b1;
                status_d = ST_FULL;
                res_d    = '0;
              end else begin
                new_d   = in_entry;
                pos_d   = count_q[AW-1:0];
                state_d = (count_q == '0) ? S_INS_WR : S_SH_RD;
              end
            end
            OP_READ: begin
              if ({1'b0, read_index_i} >= 7'(count_q)) begin
                done_d   = 1'b1;
                status_d = ST_IDX;
                res_d    = '0;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = read_index_i[AW-1:0];
                state_d   = S_RD_WAIT;
              end
            end
            OP_CLEAR: begin
              count_d  = '0;
              done_d   = 1'b1;
              status_d = ST_OK;
              res_d    = '0;
            end
            default: begin
              done_d   = 1'b1;
              status_d = ST_OK;
              res_d    = '0;
            end
          endcase
        end
      end
      S_RD_WAIT: begin
        res_d    = rdata_q;
        status_d = ST_OK;
        done_d   = 1'b1;
        state_d  = S_IDLE;
      end
      // walk down from the top, moving every entry whose start is not below the new one
      S_SH_RD: begin
        mem_re    = 1'b1;
        mem_raddr = pos_q - idx_t'(1);
        state_d   = S_SH_CHK;
      end
      S_SH_CHK: begin
        if ($signed(rdata_q.span_start) >= $signed(new_q.span_start)) begin
          mem_we    = 1'b1;
          mem_waddr = pos_q;
          mem_wdata = rdata_q;
          pos_d     = pos_q - idx_t'(1);
          state_d   = (pos_q == idx_t'(1)) ? S_INS_WR : S_SH_RD;
        end else begin
          state_d = S_INS_WR;
        end
      end
      S_INS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = pos_q;
        mem_wdata = new_q;
        count_d   = count_q + cnt_t'(1);
        state_d   = S_MG_LD;
      end
      S_MG_LD: begin
        mem_re    = 1'b1;
        mem_raddr = '0;
        state_d   = S_MG_LDW;
      end
      S_MG_LDW: begin
        run_d     = rdata_q;
        run_idx_d = '0;
        r_d       = cnt_t'(1);
        state_d   = S_MG_RD;
      end
      S_MG_RD: begin
        if (r_q == count_q) begin
          state_d = S_MG_FIN;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = r_q[AW-1:0];
          state_d   = S_MG_EVAL;
        end
      end
      // running entry lives in run_q; it is written back when a new run opens and, for the last run, in S_MG_FIN
      S_MG_EVAL: begin
        if (fold.hit) begin
          run_d.span_end = fold.new_end;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = run_idx_q;
          mem_wdata = run_q;
          run_idx_d = run_idx_q + idx_t'(1);
          run_d     = rdata_q;
        end
        r_d     = r_q + cnt_t'(1);
        state_d = S_MG_RD;
      end
      S_MG_FIN: begin
        mem_we    = 1'b1;
        mem_waddr = run_idx_q;
        mem_wdata = run_q;
        count_d   = cnt_t'(run_idx_q) + cnt_t'(1);
        done_d    = 1'b1;
        status_d  = ST_OK;
        res_d     = '0;
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
      tol_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
      if (join_tolerance_we_i) begin
        tol_q <= join_tolerance_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    r_q       <= r_d;
    pos_q     <= pos_d;
    run_idx_q <= run_idx_d;
    run_q     <= run_d;
    new_q     <= new_d;
    res_q     <= res_d;
    status_q  <= status_d;
  end

  assign busy          = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign entry_total_o = 7'(count_q);
  assign out_start_o   = res_q.span_start;
  assign out_end_o     = res_q.span_end;
  assign out_schema_o  = res_q.schema;
  assign out_hash_o    = res_q.hash;
  assign out_origin_o  = res_q.origin;

  `TISM_ASSERT(a_count_bound, count_q <= cnt_t'(MAX_ENTRIES), "entry count beyond capacity")
  `TISM_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done_o, "command dropped")
  `TISM_ASSERT_IMPL(a_fin_shrinks, state_q == S_MG_FIN, cnt_t'(run_idx_q) < count_q, "merge grew")
  `TISM_ASSERT_IMPL(a_write_in_range, mem_we, cnt_t'(mem_waddr) < cnt_t'(MAX_ENTRIES), "bad write")

endmodule
